// File: design/wsbs_pkg.sv
// ----------------------------------------------------------------------------
// wsbs_pkg
// Shared types and constants for the windowed score best-select unit.
// ----------------------------------------------------------------------------
package wsbs_pkg;

	localparam int unsigned MAX_CANDIDATES = 16;
	localparam int unsigned MAX_WINDOW     = 16;
	localparam int unsigned CFG_IDX_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_W_ACC  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_W_EFF  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_W_SPD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_W_NOV  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_W_COH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POP    = 3'd6;

	typedef struct packed {
		logic [3:0]  candidate_index;
		logic [15:0] accuracy_metric;
		logic [15:0] efficiency_metric;
		logic [15:0] speed_metric;
		logic [15:0] novelty_metric;
		logic [15:0] coherence_metric;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] new_score;
		logic [15:0] candidate_average;
		logic [3:0]  best_index;
		logic [15:0] best_average;
	} out_item_t;

	// classified job handed from the front to the back
	typedef struct packed {
		logic        valid_idx;
		logic [3:0]  idx;
		logic [15:0] score;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_WRITE, ST_SUM, ST_DIV, ST_SCAN, ST_DONE
	} back_state_t;

endpackage

// File: design/wsbs_ram.sv
// ----------------------------------------------------------------------------
// wsbs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module wsbs_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/wsbs_front.sv
// ----------------------------------------------------------------------------
// wsbs_front
// Accept items, check the index, form the saturated weighted score over
// five multiply steps, and push a job into the queue.
// ----------------------------------------------------------------------------
module wsbs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  wsbs_pkg::in_item_t item,
	output logic               busy,
	input  logic [15:0]        w_acc,
	input  logic [15:0]        w_eff,
	input  logic [15:0]        w_spd,
	input  logic [15:0]        w_nov,
	input  logic [15:0]        w_coh,
	input  logic [4:0]         pop_eff,
	input  logic               q_full,
	output logic               q_push,
	output wsbs_pkg::job_t     q_data
);

	wsbs_pkg::in_item_t item_q;
	logic        act_q;
	logic [2:0]  step_q;
	logic [34:0] acc_q;
	logic [15:0] m_sel, w_sel;
	logic [31:0] prod_s1;
	logic        pvld_s1;
	logic        vidx;

	assign busy = act_q;
	assign vidx = {1'b0, item_q.candidate_index} < pop_eff;

	always_comb begin
		case (step_q)
			3'd0: begin m_sel = item_q.accuracy_metric;   w_sel = w_acc; end
			3'd1: begin m_sel = item_q.efficiency_metric; w_sel = w_eff; end
			3'd2: begin m_sel = item_q.speed_metric;      w_sel = w_spd; end
			3'd3: begin m_sel = item_q.novelty_metric;    w_sel = w_nov; end
			default: begin m_sel = item_q.coherence_metric; w_sel = w_coh; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && !act_q) begin
			item_q <= item;
		end
		prod_s1 <= m_sel * w_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			step_q  <= '0;
			acc_q   <= '0;
			pvld_s1 <= 1'b0;
		end else begin
			pvld_s1 <= act_q && step_q < 3'd5;
			if (start && !act_q) begin
				act_q  <= 1'b1;
				step_q <= '0;
				acc_q  <= '0;
			end else if (act_q) begin
				if (step_q < 3'd5) begin
					step_q <= step_q + 3'd1;
				end
				if (pvld_s1) begin
					acc_q <= acc_q + {3'b0, prod_s1};
				end
				if (step_q == 3'd5 && !pvld_s1 && !q_full) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	assign q_push = act_q && step_q == 3'd5 && !pvld_s1 && !q_full;
	always_comb begin
		q_data.valid_idx = vidx;
		q_data.idx       = item_q.candidate_index;
		if (!vidx) begin
			q_data.score = '0;
		end else if (acc_q[34:32] != 3'b0) begin
			q_data.score = 16'hFFFF;
		end else begin
			q_data.score = acc_q[31:16];
		end
	end

endmodule

// File: design/wsbs_queue.sv
// ----------------------------------------------------------------------------
// wsbs_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module wsbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wsbs_pkg::job_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output wsbs_pkg::job_t rdata
);

	wsbs_pkg::job_t slot_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign rdata     = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count invalid");
`endif

endmodule

// File: design/wsbs_back.sv
// ----------------------------------------------------------------------------
// wsbs_back
// Update history, sum the window, divide by restoring steps, scan the
// stored averages and emit one result per job.
// ----------------------------------------------------------------------------
module wsbs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          win_eff,
	input  logic [4:0]          pop_eff,
	input  logic                q_valid,
	input  wsbs_pkg::job_t      q_data,
	output logic                q_pop,
	output logic                done,
	output wsbs_pkg::out_item_t result
);

	wsbs_pkg::back_state_t state_q, state_d;
	wsbs_pkg::job_t job_q;
	logic [4:0]  cnt_q [16];
	logic [3:0]  wp_q [16];
	logic [15:0] avg_q [16];
	logic [4:0]  n_q, k_q;
	logic [19:0] sum_q;
	logic [15:0] quo_q;
	logic [4:0]  rem_q;
	logic [4:0]  dstep_q;
	logic [3:0]  bi_q;
	logic [15:0] ba_q;
	logic [4:0]  si_q;
	logic [15:0] cavg_q;
	logic        rd_vld_s1;
	logic [7:0]  raddr;
	logic [15:0] rdata;
	logic        we;
	logic [3:0]  rpos;
	logic [5:0]  trial;
	logic [4:0]  n_new;

	assign we   = state_q == wsbs_pkg::ST_WRITE && job_q.valid_idx;
	assign rpos = wp_q[job_q.idx] - 4'd1 - k_q[3:0];
	assign raddr = {job_q.idx, rpos};
	assign trial = {rem_q, sum_q[19]};
	assign n_new = (cnt_q[job_q.idx] < win_eff) ? cnt_q[job_q.idx] : win_eff;

	wsbs_ram #(.WIDTH(16), .DEPTH(256)) u_hist (
		.clk(clk), .we(we), .waddr({job_q.idx, wp_q[job_q.idx]}),
		.wdata(job_q.score), .raddr(raddr), .rdata(rdata)
	);

	assign q_pop = state_q == wsbs_pkg::ST_IDLE && q_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			wsbs_pkg::ST_IDLE:  if (q_valid) state_d = wsbs_pkg::ST_WRITE;
			wsbs_pkg::ST_WRITE: state_d = job_q.valid_idx ? wsbs_pkg::ST_SUM
				: wsbs_pkg::ST_SCAN;
			wsbs_pkg::ST_SUM:   if (k_q == n_q && !rd_vld_s1) state_d = wsbs_pkg::ST_DIV;
			wsbs_pkg::ST_DIV:   if (dstep_q == 5'd20) state_d = wsbs_pkg::ST_SCAN;
			wsbs_pkg::ST_SCAN:  if (si_q >= pop_eff) state_d = wsbs_pkg::ST_DONE;
			wsbs_pkg::ST_DONE:  state_d = wsbs_pkg::ST_IDLE;
			default:            state_d = wsbs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wsbs_pkg::ST_IDLE;
			rd_vld_s1 <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				cnt_q[i] <= '0;
				wp_q[i]  <= '0;
				avg_q[i] <= '0;
			end
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= state_q == wsbs_pkg::ST_SUM && k_q != n_q;
			if (we) begin
				wp_q[job_q.idx] <= wp_q[job_q.idx] + 4'd1;
				if (cnt_q[job_q.idx] != 5'd16) begin
					cnt_q[job_q.idx] <= cnt_q[job_q.idx] + 5'd1;
				end
			end
			if (state_q == wsbs_pkg::ST_DIV && dstep_q == 5'd20) begin
				avg_q[job_q.idx] <= quo_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wsbs_pkg::ST_IDLE: begin
				job_q  <= q_data;
				cavg_q <= '0;
			end
			wsbs_pkg::ST_WRITE: begin
				n_q   <= (cnt_q[job_q.idx] == 5'd16) ? win_eff : n_new + 5'd0;
				k_q   <= '0;
				sum_q <= '0;
				si_q  <= 5'd1;
				bi_q  <= '0;
				ba_q  <= avg_q[0];
				if (cnt_q[job_q.idx] != 5'd16) begin
					n_q <= ((cnt_q[job_q.idx] + 5'd1) < win_eff)
						? cnt_q[job_q.idx] + 5'd1 : win_eff;
				end
			end
			wsbs_pkg::ST_SUM: begin
				if (k_q != n_q) k_q <= k_q + 5'd1;
				if (rd_vld_s1) sum_q <= sum_q + {4'b0, rdata};
				dstep_q <= '0;
				rem_q   <= '0;
				quo_q   <= '0;
			end
			wsbs_pkg::ST_DIV: begin
				if (dstep_q != 5'd20) begin
					dstep_q <= dstep_q + 5'd1;
					sum_q   <= {sum_q[18:0], 1'b0};
					if (trial >= {1'b0, n_q}) begin
						rem_q <= 5'(trial - {1'b0, n_q});
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= trial[4:0];
						quo_q <= {quo_q[14:0], 1'b0};
					end
				end else begin
					cavg_q <= quo_q;
					if (job_q.idx == 4'd0) ba_q <= quo_q;
				end
			end
			wsbs_pkg::ST_SCAN: begin
				if (si_q < pop_eff) begin
					si_q <= si_q + 5'd1;
					if (avg_q[si_q[3:0]] > ba_q) begin
						ba_q <= avg_q[si_q[3:0]];
						bi_q <= si_q[3:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done = state_q == wsbs_pkg::ST_DONE;
	always_comb begin
		result.accepted          = job_q.valid_idx;
		result.new_score         = job_q.score;
		result.candidate_average = cavg_q;
		result.best_index        = (pop_eff == 5'd0) ? 4'd0 : bi_q;
		result.best_average      = (pop_eff == 5'd0) ? 16'd0 : ba_q;
	end

`ifndef ASSERT_OFF
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == wsbs_pkg::ST_WRITE) else $error("pop without write");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double result");
	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wsbs_pkg::ST_DIV |-> n_q != 5'd0) else $error("zero divisor");
`endif

endmodule

// File: design/windowed_score_best_select_unit.sv
// The back sums the n stored scores of the window, divides by n, then scans the p candidates
// for the best average; an ignored (out-of-range) index skips the sum and the divide.
// The front can score the next item while the back is still busy; a two-job queue between
// them lets them overlap, and the front waits while the queue is full.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset: asynchronous; loads the config defaults and clears counts, pointers and averages.
// ----------------------------------------------------------------------------
// windowed_score_best_select_unit
// Top level: config registers, front scorer, job queue, back-end selector.
// ----------------------------------------------------------------------------
module windowed_score_best_select_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  wsbs_pkg::in_item_t  item,
	output logic                busy,
	output logic                done,
	output wsbs_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	logic [15:0] w_acc_q, w_eff_q, w_spd_q, w_nov_q, w_coh_q;
	logic [4:0]  win_q, pop_q, win_eff, pop_eff;
	logic        q_push, q_full, q_pop, q_valid;
	wsbs_pkg::job_t q_in, q_out;

	assign win_eff = (win_q == 5'd0) ? 5'd1 : ((win_q > 5'd16) ? 5'd16 : win_q);
	assign pop_eff = (pop_q > 5'd16) ? 5'd16 : pop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_acc_q <= 16'd26214;
			w_eff_q <= 16'd13107;
			w_spd_q <= 16'd13107;
			w_nov_q <= 16'd6554;
			w_coh_q <= 16'd6554;
			win_q   <= 5'd10;
			pop_q   <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				wsbs_pkg::REG_W_ACC:  w_acc_q <= cfg_data;
				wsbs_pkg::REG_W_EFF:  w_eff_q <= cfg_data;
				wsbs_pkg::REG_W_SPD:  w_spd_q <= cfg_data;
				wsbs_pkg::REG_W_NOV:  w_nov_q <= cfg_data;
				wsbs_pkg::REG_W_COH:  w_coh_q <= cfg_data;
				wsbs_pkg::REG_WINDOW: win_q   <= cfg_data[4:0];
				wsbs_pkg::REG_POP:    pop_q   <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	wsbs_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.w_acc(w_acc_q), .w_eff(w_eff_q), .w_spd(w_spd_q), .w_nov(w_nov_q),
		.w_coh(w_coh_q), .pop_eff(pop_eff), .q_full(q_full), .q_push(q_push),
		.q_data(q_in)
	);

	wsbs_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wdata(q_in), .full(q_full),
		.pop(q_pop), .not_empty(q_valid), .rdata(q_out)
	);

	wsbs_back u_back (
		.clk(clk), .arst_n(arst_n), .win_eff(win_eff), .pop_eff(pop_eff),
		.q_valid(q_valid), .q_data(q_out), .q_pop(q_pop), .done(done),
		.result(result)
	);

endmodule
